FILE: rtl/scp_pkg.sv
package scp_pkg;

   localparam int CHANNEL_BITS    = 16;
   localparam int SINE_TABLE_BITS = 10;
   localparam int FIELD_BITS      = 16;
   localparam int GAIN_BITS       = 16;
   localparam int GAIN_FRAC       = 12;
   localparam int PHASE_BITS      = GAIN_FRAC + CHANNEL_BITS;
   localparam int QUARTER         = 2 ** (SINE_TABLE_BITS - 2);

   localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(4096);
   localparam logic [CHANNEL_BITS-1:0] HALF = CHANNEL_BITS'(1) << (CHANNEL_BITS - 1);
   localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = {CHANNEL_BITS{1'b1}};

   localparam longint unsigned Q30_HALF = 64'd536870912;
   localparam longint unsigned COEF_1   = 64'd1686629713;
   localparam longint unsigned COEF_3   = 64'd693598668;
   localparam longint unsigned COEF_5   = 64'd85569306;
   localparam longint unsigned COEF_7   = 64'd5026995;
   localparam longint unsigned COEF_9   = 64'd172272;

   typedef struct packed {
      logic [FIELD_BITS-1:0] red_in;
      logic [FIELD_BITS-1:0] green_in;
      logic [FIELD_BITS-1:0] blue_in;
      logic [FIELD_BITS-1:0] alpha_in;
   } pixel_in_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] red_out;
      logic [FIELD_BITS-1:0] green_out;
      logic [FIELD_BITS-1:0] blue_out;
      logic [FIELD_BITS-1:0] alpha_out;
   } pixel_out_type;

   typedef logic [QUARTER-1:0][CHANNEL_BITS-1:0] sine_table_type;

   // half-scale sine magnitude for quarter position r, odd polynomial in q30
   function automatic logic [CHANNEL_BITS-1:0] sine_mag(input int unsigned r);
      longint unsigned x, x2, x3, x5, x7, x9, pos, neg, m, d;
      x   = longint'(r) << (30 - (SINE_TABLE_BITS - 2));
      x2  = (x * x) >> 30;
      x3  = (x2 * x) >> 30;
      x5  = (x3 * x2) >> 30;
      x7  = (x5 * x2) >> 30;
      x9  = (x7 * x2) >> 30;
      pos = COEF_1 * x + COEF_5 * x5 + COEF_9 * x9;
      neg = COEF_3 * x3 + COEF_7 * x7;
      m   = (pos > neg) ? ((pos - neg + Q30_HALF) >> 30) : 64'd0;
      d   = ((m << (CHANNEL_BITS - 1)) + Q30_HALF) >> 30;
      return CHANNEL_BITS'(d);
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type tab;
      for (int i = 0; i < QUARTER; i++) begin
         tab[i] = sine_mag(i);
      end
      return tab;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();
   localparam logic [CHANNEL_BITS-1:0] SINE_PEAK = sine_mag(QUARTER);

endpackage

FILE: rtl/scp_lane.sv
module scp_lane (
   input  logic                           clock,
   input  logic                           advance,
   input  logic [scp_pkg::FIELD_BITS-1:0] code,
   input  logic [scp_pkg::GAIN_BITS-1:0]  gain,
   output logic [scp_pkg::FIELD_BITS-1:0] mapped
);
   import scp_pkg::*;

   localparam int PROD_BITS = CHANNEL_BITS + GAIN_BITS;

   logic [CHANNEL_BITS-1:0]    chan;
   logic [PROD_BITS-1:0]       product;
   logic [SINE_TABLE_BITS-1:0] k_in;
   logic [SINE_TABLE_BITS-1:0] k_ff;
   logic [1:0]                 quad;
   logic [SINE_TABLE_BITS-2:0] pos;
   logic [CHANNEL_BITS-1:0]    d;
   logic [CHANNEL_BITS:0]      sum;
   logic [CHANNEL_BITS-1:0]    result;

   assign chan    = CHANNEL_BITS'(code);
   assign product = PROD_BITS'(chan) * PROD_BITS'(gain);
   // whole turns drop out, top fraction bits index the sine
   assign k_in    = product[PHASE_BITS-1 -: SINE_TABLE_BITS];

   always_ff @(posedge clock) begin
      if (advance) begin
         k_ff <= k_in;
      end
   end

   assign quad = k_ff[SINE_TABLE_BITS-1 -: 2];

   always_comb begin
      pos = {1'b0, k_ff[SINE_TABLE_BITS-3:0]};
      if (quad[0]) begin
         pos = (SINE_TABLE_BITS-1)'(QUARTER) - pos;
      end
      if (pos[SINE_TABLE_BITS-2]) begin
         d = SINE_PEAK;
      end else begin
         d = SINE_TABLE[pos[SINE_TABLE_BITS-3:0]];
      end
      sum = {1'b0, HALF} + {1'b0, d};
      if (!quad[1]) begin
         result = sum[CHANNEL_BITS] ? CHAN_MAX : sum[CHANNEL_BITS-1:0];
      end else begin
         result = (d >= HALF) ? '0 : HALF - d;
      end
   end

   assign mapped = FIELD_BITS'(result);

endmodule

FILE: rtl/scp_merge.sv
module scp_merge (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           stage_valid,
   input  logic [scp_pkg::FIELD_BITS-1:0] red,
   input  logic [scp_pkg::FIELD_BITS-1:0] green,
   input  logic [scp_pkg::FIELD_BITS-1:0] blue,
   input  logic [scp_pkg::FIELD_BITS-1:0] alpha,
   output logic                           rsp_valid,
   output scp_pkg::pixel_out_type         rsp_data
);
   import scp_pkg::*;

   logic          valid_ff;
   pixel_out_type data_in;
   pixel_out_type data_ff;

   always_comb begin
      data_in.red_out   = red;
      data_in.green_out = green;
      data_in.blue_out  = blue;
      data_in.alpha_out = alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: rtl/sine_contrast_pixel_map.sv
// a pixel accepted into the lane stage registers is offered on rsp from the merge output register
// throughput: one pixel per cycle while rsp is not stalled, set by the two-stage lane pipeline
// (gain multiply, then sine table lookup into the output register)
// the whole pipeline holds while a result waits for rsp_ready
// reset clears all valid flags and loads the gain register with 1.0
module sine_contrast_pixel_map (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  scp_pkg::pixel_in_type         req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output scp_pkg::pixel_out_type        rsp_data,
   input  logic                          csr_wr_en,
   input  logic [scp_pkg::GAIN_BITS-1:0] csr_wr_data
);
   import scp_pkg::*;

   logic [GAIN_BITS-1:0]  gain_ff;
   logic [GAIN_BITS-1:0]  gain_eff;
   logic                  advance;
   logic                  s1_valid_ff;
   logic [FIELD_BITS-1:0] alpha_ff;
   logic [FIELD_BITS-1:0] red_map;
   logic [FIELD_BITS-1:0] green_map;
   logic [FIELD_BITS-1:0] blue_map;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_ONE;
      end else if (csr_wr_en) begin
         gain_ff <= csr_wr_data;
      end
   end

   // zero gain counts as one turn
   assign gain_eff  = (gain_ff == '0) ? GAIN_ONE : gain_ff;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         alpha_ff <= req_data.alpha_in;
      end
   end

   scp_lane u_lane_red (
      .clock   (clock),
      .advance (advance),
      .code    (req_data.red_in),
      .gain    (gain_eff),
      .mapped  (red_map)
   );

   scp_lane u_lane_green (
      .clock   (clock),
      .advance (advance),
      .code    (req_data.green_in),
      .gain    (gain_eff),
      .mapped  (green_map)
   );

   scp_lane u_lane_blue (
      .clock   (clock),
      .advance (advance),
      .code    (req_data.blue_in),
      .gain    (gain_eff),
      .mapped  (blue_map)
   );

   scp_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .stage_valid (s1_valid_ff),
      .red         (red_map),
      .green       (green_map),
      .blue        (blue_map),
      .alpha       (alpha_ff),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule
